// ===== src/i2rd_pkg.sv =====
`default_nettype none

package i2rd_pkg;

    // Alphabet table
    localparam int MAX_BASE = 64;
    localparam int TBL_AW   = $clog2(MAX_BASE);
    localparam int BASE_W   = 7;

    // Digit stack: 2**31 in radix 2 has 32 digits
    localparam int STK_DEPTH = 32;
    localparam int STK_AW    = $clog2(STK_DEPTH);
    localparam int SP_W      = STK_AW + 1;

    // Magnitude and restoring divider
    localparam int MAG_W     = 33;
    localparam int DIV_CNT_W = $clog2(MAG_W);
    localparam int REM_W     = TBL_AW;

    // Config port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_RADIX = 1'b0;

    // Input command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LOW   = 8'h20;
    localparam logic [7:0] CH_HIGH  = 8'h7E;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_RD,
        ST_CHK_EVAL,
        ST_DIV,
        ST_PUSH,
        ST_SIGN,
        ST_POP,
        ST_TBL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_wr;
        logic chk_init;
        logic chk_rd;
        logic chk_eval;
        logic div_init;
        logic div_step;
        logic push;
        logic emit_minus;
        logic pop_rd;
        logic tbl_rd;
        logic emit_digit;
    } dp_cmd_t;

    typedef struct packed {
        logic base_ok;
        logic chk_last;
        logic char_bad;
        logic div_last;
        logic quot_zero;
        logic stack_empty;
        logic neg;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/i2rd_ctrl.sv =====
`default_nettype none

module i2rd_ctrl
    import i2rd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    command,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd,
    output logic         busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && command == CMD_CONVERT && sts.base_ok)
                begin
                    state_next = ST_CHK_RD;
                end
            end
            ST_CHK_RD:
            begin
                state_next = ST_CHK_EVAL;
            end
            ST_CHK_EVAL:
            begin
                if (sts.char_bad)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.chk_last)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_CHK_RD;
                end
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!sts.quot_zero)
                begin
                    state_next = ST_DIV;
                end
                else if (sts.neg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_POP;
            end
            ST_POP:
            begin
                state_next = ST_TBL;
            end
            ST_TBL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                state_next = sts.stack_empty ? ST_IDLE : ST_POP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load_wr  = (command == CMD_LOAD);
                    cmd.chk_init = (command == CMD_CONVERT);
                end
            end
            ST_CHK_RD:
            begin
                cmd.chk_rd = 1'b1;
            end
            ST_CHK_EVAL:
            begin
                cmd.chk_eval = !sts.char_bad;
                cmd.div_init = !sts.char_bad && sts.chk_last;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_PUSH:
            begin
                cmd.push     = 1'b1;
                cmd.div_init = !sts.quot_zero;
            end
            ST_SIGN:
            begin
                cmd.emit_minus = 1'b1;
            end
            ST_POP:
            begin
                cmd.pop_rd = 1'b1;
            end
            ST_TBL:
            begin
                cmd.tbl_rd = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_digit = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/i2rd_dp.sv =====
`default_nettype none

module i2rd_dp
    import i2rd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dp_cmd_t             cmd,
    input  wire logic [BASE_W-1:0]   radix,
    input  wire logic [TBL_AW-1:0]   digit_index,
    input  wire logic [7:0]          digit_char,
    input  wire logic signed [31:0]  value,
    output dp_sts_t                  sts,
    output logic                     out_valid,
    output logic [7:0]               out_char,
    output logic                     last
);

    // Memories
    logic [7:0]       tbl_mem [MAX_BASE];
    logic [REM_W-1:0] stk_mem [STK_DEPTH];

    logic [7:0]           tbl_rdata_reg;
    logic [REM_W-1:0]     stk_rdata_reg;

    // Alphabet check
    logic [TBL_AW-1:0]    idx_reg;
    logic [127:0]         seen_reg;

    // Divider
    logic [MAG_W-1:0]     mag_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;
    logic [SP_W-1:0]      sp_reg;

    logic                 out_valid_reg;
    logic [7:0]           out_char_reg;
    logic                 last_reg;

    logic [MAG_W-1:0]     mag_init;
    logic [REM_W:0]       div_r;
    logic [REM_W:0]       div_sub;
    logic                 div_ge;
    logic [SP_W-1:0]      sp_dec;
    logic [TBL_AW-1:0]    tbl_raddr;

    // 2**32 - v for negatives, held in 33 bits
    assign mag_init = value[31] ? (MAG_W'(0) - {1'b1, value})
                                : {1'b0, value};

    assign div_r   = {rem_reg, mag_reg[MAG_W-1]};
    assign div_ge  = ({1'b0, div_r} >= {1'b0, radix});
    assign div_sub = div_r - radix;
    assign sp_dec  = sp_reg - SP_W'(1);

    assign tbl_raddr = cmd.tbl_rd ? stk_rdata_reg : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            tbl_mem[digit_index] <= digit_char;
        end
        if (cmd.chk_rd || cmd.tbl_rd)
        begin
            tbl_rdata_reg <= tbl_mem[tbl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stk_mem[sp_reg[STK_AW-1:0]] <= rem_reg;
        end
        if (cmd.pop_rd)
        begin
            stk_rdata_reg <= stk_mem[sp_dec[STK_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.chk_init)
        begin
            idx_reg  <= '0;
            seen_reg <= '0;
            mag_reg  <= mag_init;
            neg_reg  <= value[31];
            sp_reg   <= '0;
        end
        else
        begin
            if (cmd.chk_eval)
            begin
                idx_reg <= idx_reg + TBL_AW'(1);
                seen_reg[tbl_rdata_reg[6:0]] <= 1'b1;
            end
            if (cmd.div_step)
            begin
                mag_reg <= {mag_reg[MAG_W-2:0], div_ge};
            end
            if (cmd.push)
            begin
                sp_reg <= sp_reg + SP_W'(1);
            end
            else if (cmd.pop_rd)
            begin
                sp_reg <= sp_dec;
            end
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_sub[REM_W-1:0] : div_r[REM_W-1:0];
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= cmd.emit_minus || cmd.emit_digit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_minus)
        begin
            out_char_reg <= CH_MINUS;
            last_reg     <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_char_reg <= tbl_rdata_reg;
            last_reg     <= (sp_reg == '0);
        end
    end

    always_comb
    begin
        sts.base_ok     = (radix >= BASE_W'(2)) && (radix <= BASE_W'(MAX_BASE));
        sts.chk_last    = ({1'b0, idx_reg} == (radix - BASE_W'(1)));
        sts.char_bad    = (tbl_rdata_reg < CH_LOW) || (tbl_rdata_reg > CH_HIGH)
                       || (tbl_rdata_reg == CH_PLUS) || (tbl_rdata_reg == CH_MINUS)
                       || seen_reg[tbl_rdata_reg[6:0]];
        sts.div_last    = (cnt_reg == DIV_CNT_W'(MAG_W - 1));
        sts.quot_zero   = (mag_reg == '0);
        sts.stack_empty = (sp_reg == '0);
        sts.neg         = neg_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== src/int_to_radix_digits.sv =====
// Signed 32-bit integer to text in a radix of 2..64 (the radix register),
// using an alphabet loaded one character per load transaction. A transaction
// is taken when start is high and busy is low. A load (command = 0) writes
// digit_char at digit_index and gives no output. A convert (command = 1)
// first checks the alphabet (a table read and then a compare for each entry,
// duplicates tracked in a seen-bitmap); a bad alphabet or a radix outside
// 2..64 ends the transaction with no output. Each digit then comes from the
// bit-serial restoring divider (33 quotient bits, then a push onto the digit
// stack), and each character comes out through the stack and alphabet
// memories (pop, table read, emit), with an extra state for a leading minus.
// Worst case is radix 2 with the most negative value; a radix of 64 has the
// longest check but at most 6 digits. Characters appear on out_char/last
// for exactly one cycle with out_valid high; there is no backpressure, the
// receiver must take every one. The radix is to be written over the APB
// port only while busy is low; the block itself does not enforce this.
`default_nettype none

module int_to_radix_digits
    import i2rd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // APB config port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,

    // Command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               command,
    input  wire logic [TBL_AW-1:0]  digit_index,
    input  wire logic [7:0]         digit_char,
    input  wire logic signed [31:0] value,

    // Character stream
    output logic                    out_valid,
    output logic [7:0]              out_char,
    output logic                    last
);

    logic [BASE_W-1:0] radix_reg;
    logic [BASE_W-1:0] radix_next;
    logic              cfg_wr;
    dp_cmd_t           cmd;
    dp_sts_t           sts;

    // Register index is paddr[2]; only the radix register exists
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RADIX);
    assign pready = 1'b1;

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_wr)
        begin
            radix_next = pwdata[BASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= '0;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    assign prdata = (paddr[2] == REG_RADIX)
                  ? {{(DATA_W-BASE_W){1'b0}}, radix_reg} : '0;

    i2rd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy)
    );

    i2rd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .radix       (radix_reg),
        .digit_index (digit_index),
        .digit_char  (digit_char),
        .value       (value),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_char    (out_char),
        .last        (last)
    );

endmodule

`default_nettype wire

// ===== src/i2rd_checker.sv =====
`default_nettype none

module i2rd_checker
    import i2rd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       out_valid,
    input wire logic [7:0] out_char,
    input wire logic       last
);

    // Nothing can be emitted right after a transaction is taken
    a_no_out_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !out_valid)
        else $error("character right after accepted transaction");

    // Characters are spaced by the stack and table reads
    a_out_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |=> !out_valid)
        else $error("back-to-back characters");

    // Mid-conversion the block stays busy
    a_busy_mid_string: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> busy)
        else $error("busy dropped before last character");

    // A minus sign never ends a string
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_char == CH_MINUS) |-> !last)
        else $error("minus flagged last");

endmodule

bind int_to_radix_digits i2rd_checker u_i2rd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .out_char  (out_char),
    .last      (last)
);

`default_nettype wire

// ===== bench/tb.sv =====
// Bench for int_to_radix_digits.
// A predictor keeps its own alphabet table and radix copy and works out
// the character stream for every accepted convert transaction. A monitor
// checks each strobed character against the oldest pending one.

`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2rd_pkg::*;

    // Worst case convert is radix 2 with the most negative value (see DUT header); pad it.
    localparam int DRAIN_CYCLES = 1400;
    // ~460 transactions at worst case plus idle bursts and drains, times ~6.
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_ITEMS = 340;
    // No sender idling over the last stretch of random traffic
    localparam int QUIET_TAIL   = 60;

    // Register i sits at byte address 4*i; index 1 is unmapped.
    localparam logic [ADDR_W-1:0] RADIX_ADDR = ADDR_W'(4 * int'(REG_RADIX));
    localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    // Ways to spoil an otherwise valid alphabet
    typedef enum int {
        FLAW_DUP,
        FLAW_PLUS,
        FLAW_MINUS,
        FLAW_LOW,
        FLAW_HIGH
    } flaw_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [ADDR_W-1:0]  paddr       = '0;
    logic [DATA_W-1:0]  pwdata      = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               start       = 1'b0;
    logic               busy;
    logic               command     = 1'b0;
    logic [TBL_AW-1:0]  digit_index = '0;
    logic [7:0]         digit_char  = '0;
    logic signed [31:0] value       = '0;
    logic               out_valid;
    logic [7:0]         out_char;
    logic               last;

    // Predictor state
    logic [7:0]         alpha_tbl [MAX_BASE];
    logic [BASE_W-1:0]  radix_cfg = '0;
    text_char_t         pending_chars [$];

    bit                 gaps_on = 1'b1;
    int                 errors      = 0;
    int                 items_sent  = 0;
    int                 n_loads     = 0;
    int                 n_converts  = 0;
    int                 n_chars     = 0;
    int                 n_cfg       = 0;
    int                 cycle_cnt   = 0;
    text_char_t         head_char;

    int_to_radix_digits dut (.*);

    always #4 clk = ~clk;

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    // Watchdog: anything hung (missing characters, busy stuck) ends here.
    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("%0t ns: timeout after %0d cycles, %0d characters still pending",
                 $time, cycle_cnt, pending_chars.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Result monitor. No backpressure: every strobed character is a
    // completed transaction on the output side.
    always @(posedge clk)
    begin
        if (rst_n && out_valid)
        begin
            n_chars++;
            if (pending_chars.size() == 0)
            begin
                $display("%0t ns: unexpected character, expected none got 0x%02h last=%0b",
                         $time, out_char, last);
                errors++;
            end
            else
            begin
                head_char = pending_chars.pop_front();
                if (out_char !== head_char.ch)
                begin
                    $display("%0t ns: out_char mismatch, expected 0x%02h got 0x%02h",
                             $time, head_char.ch, out_char);
                    errors++;
                end
                if (last !== head_char.last)
                begin
                    $display("%0t ns: last mismatch, expected %0b got %0b",
                             $time, head_char.last, last);
                    errors++;
                end
            end
        end
    end

    // Alphabet rule: 2..MAX_BASE entries, printable, no sign chars, unique.
    function automatic bit alphabet_valid();
        logic [7:0] c;
        if (radix_cfg < 2 || radix_cfg > MAX_BASE)
            return 1'b0;
        for (int i = 0; i < radix_cfg; i++)
        begin
            c = alpha_tbl[i];
            if (c == CH_PLUS || c == CH_MINUS)
                return 1'b0;
            if (c < CH_LOW || c > CH_HIGH)
                return 1'b0;
            for (int j = i + 1; j < radix_cfg; j++)
                if (alpha_tbl[j] == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Queue up the text of one conversion. The 33-bit magnitude keeps the
    // most negative input exact.
    function automatic void predict_text(input logic [31:0] val);
        logic [32:0] mag;
        logic [32:0] radix;
        logic [7:0]  digits [$];
        if (!alphabet_valid())
            return;
        radix = 33'(radix_cfg);
        mag   = val[31] ? (33'h1_0000_0000 - {1'b0, val}) : {1'b0, val};
        do
        begin
            digits.push_front(alpha_tbl[int'(mag % radix)]);
            mag = mag / radix;
        end
        while (mag != 0);
        // Sign never closes the stream
        if (val[31])
            pending_chars.push_back('{CH_MINUS, 1'b0});
        foreach (digits[i])
            pending_chars.push_back('{digits[i], i == digits.size() - 1});
    endfunction

    // Default alphabet: 0-9, A-Z, a-z, then '#' and '@'.
    function automatic logic [7:0] std_digit(input int i);
        if (i < 10)
            return 8'(8'h30 + i);
        else if (i < 36)
            return 8'(8'h41 + i - 10);
        else if (i < 62)
            return 8'(8'h61 + i - 36);
        else if (i == 62)
            return 8'h23;
        return 8'h40;
    endfunction

    // Mostly spread values, with a share of the edges and of small numbers.
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 6))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    3: return 32'h7FFF_FFFF;
                    4: return 32'h8000_0001;
                    5: return 32'(radix_cfg);
                    default: return 32'(radix_cfg) - 32'd1;
                endcase
            end
            1, 2, 3, 4: return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return $urandom();
        endcase
    endfunction

    // One transaction on the command channel. start is left high on return
    // so a back-to-back transaction does not drop it in between.
    task automatic send_item(input logic cmd, input logic [TBL_AW-1:0] idx,
                             input logic [7:0] ch, input logic [31:0] val);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        digit_index <= idx;
        digit_char  <= ch;
        value       <= val;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (cmd == CMD_LOAD)
        begin
            alpha_tbl[idx] = ch;
            n_loads++;
        end
        else
        begin
            n_converts++;
            predict_text(val);
        end
    endtask

    // Unused fields get random values to show they are ignored.
    task automatic load_digit(input logic [TBL_AW-1:0] idx, input logic [7:0] ch);
        send_item(CMD_LOAD, idx, ch, $urandom());
    endtask

    task automatic convert(input logic [31:0] val);
        send_item(CMD_CONVERT, TBL_AW'($urandom()), 8'($urandom()), val);
    endtask

    // Quiesce before touching config: drop start, drain pending text, then
    // allow for a convert that failed its check and so emits nothing.
    task automatic settle();
        start <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // APB: setup cycle, then access until pready.
    task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_radix_readback();
        logic [DATA_W-1:0] rd;
        apb_xfer(1'b0, RADIX_ADDR, '0, rd);
        if (rd[BASE_W-1:0] !== radix_cfg)
        begin
            $display("%0t ns: radix readback mismatch, expected %0d got %0d",
                     $time, radix_cfg, rd[BASE_W-1:0]);
            errors++;
        end
    endtask

    // Upper data bits are junk; only the low BASE_W bits land.
    task automatic write_radix(input logic [BASE_W-1:0] b);
        logic [DATA_W-1:0] w;
        logic [DATA_W-1:0] rd;
        w = $urandom();
        w[BASE_W-1:0] = b;
        settle();
        apb_xfer(1'b1, RADIX_ADDR, w, rd);
        radix_cfg = b;
        n_cfg++;
        check_radix_readback();
    endtask

    // Reset value, and a write to an unmapped address must not land.
    task automatic test_config_port();
        logic [DATA_W-1:0] rd;
        check_radix_readback();
        apb_xfer(1'b1, SPARE_ADDR, DATA_W'(MAX_BASE), rd);
        check_radix_readback();
    endtask

    // Every entry written once, so no convert ever reads an unwritten one.
    task automatic test_fill_table();
        for (int i = 0; i < MAX_BASE; i++)
            load_digit(TBL_AW'(i), std_digit(i));
    endtask

    task automatic test_decimal();
        write_radix(BASE_W'(10));
        convert(32'd0);
        convert(32'd9);
        convert(32'd10);
        convert(-32'sd1);
        convert(32'h7FFF_FFFF);
        convert(32'h8000_0000);
        convert(-32'sd987);
    endtask

    // Longest output (radix 2, most negative) and widest alphabet.
    task automatic test_radix_extremes();
        write_radix(BASE_W'(2));
        convert(32'h8000_0000);
        convert(32'h7FFF_FFFF);
        convert(-32'sd1);
        convert(32'd5);
        write_radix(BASE_W'(MAX_BASE));
        convert(32'h8000_0000);
        convert(-32'sd1);
        convert(32'd63);
        convert(32'd64);
    endtask

    // Every way the check can fail gives no text; edge chars are accepted.
    task automatic test_bad_alphabet();
        logic [7:0] bad_chars [5];
        bad_chars = '{CH_PLUS, CH_MINUS, 8'h1F, 8'h7F, 8'hFF};
        write_radix(BASE_W'(0));
        convert(32'd123);
        write_radix(BASE_W'(1));
        convert(32'd123);
        write_radix(BASE_W'(MAX_BASE + 1));
        convert(32'd123);
        write_radix(BASE_W'(127));
        convert(32'd123);

        write_radix(BASE_W'(4));
        foreach (bad_chars[i])
        begin
            load_digit(TBL_AW'(2), bad_chars[i]);
            convert(-32'sd5);
        end
        // duplicate of entry 0
        load_digit(TBL_AW'(2), std_digit(2));
        load_digit(TBL_AW'(3), std_digit(0));
        convert(32'd7);
        // space and tilde are legal digits
        load_digit(TBL_AW'(0), CH_LOW);
        load_digit(TBL_AW'(3), CH_HIGH);
        convert(32'd255);
        convert(-32'sd256);
        load_digit(TBL_AW'(0), std_digit(0));
        load_digit(TBL_AW'(3), std_digit(3));
    endtask

    // Phases: new radix, a fresh shuffled alphabet (sometimes spoiled),
    // then a burst of converts with the odd stray load mixed in.
    task automatic test_random();
        logic [7:0] pool [93];
        logic [7:0] t;
        int         n;
        int         j;
        int         k;
        int         sel;
        int         base;
        int         burst;
        int         first;
        n = 0;
        for (int c = CH_LOW; c <= CH_HIGH; c++)
            if (c != CH_PLUS && c != CH_MINUS)
                pool[n++] = 8'(c);
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            gaps_on = (items_sent - first < RANDOM_ITEMS - QUIET_TAIL) &&
                      ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 9);
            if (sel == 0)
                base = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1)
                                                   : $urandom_range(MAX_BASE + 1, 127);
            else if (sel == 1)
                base = $urandom_range(0, 1) ? MAX_BASE : 2;
            else if (sel < 7)
                base = $urandom_range(2, 16);
            else
                base = $urandom_range(17, MAX_BASE);
            write_radix(BASE_W'(base));

            if (base >= 2 && base <= MAX_BASE)
            begin
                for (int i = n - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    t = pool[i];
                    pool[i] = pool[j];
                    pool[j] = t;
                end
                for (int i = 0; i < base; i++)
                    load_digit(TBL_AW'(i), pool[i]);
                if ($urandom_range(0, 3) == 0)
                begin
                    j = $urandom_range(0, base - 1);
                    case (flaw_t'($urandom_range(0, 4)))
                        FLAW_DUP:
                        begin
                            j = $urandom_range(1, base - 1);
                            k = $urandom_range(0, j - 1);
                            load_digit(TBL_AW'(j), alpha_tbl[k]);
                        end
                        FLAW_PLUS:  load_digit(TBL_AW'(j), CH_PLUS);
                        FLAW_MINUS: load_digit(TBL_AW'(j), CH_MINUS);
                        FLAW_LOW:   load_digit(TBL_AW'(j), 8'($urandom_range(0, CH_LOW - 1)));
                        default:    load_digit(TBL_AW'(j), 8'($urandom_range(CH_HIGH + 1, 255)));
                    endcase
                end
                burst = $urandom_range(8, 24);
            end
            else
                burst = $urandom_range(2, 4);

            repeat (burst)
            begin
                if ($urandom_range(0, 19) == 0)
                    load_digit(TBL_AW'($urandom()), 8'($urandom_range(0, 255)));
                else
                    convert(rand_value());
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_config_port();
        test_fill_table();
        test_decimal();
        test_radix_extremes();
        test_bad_alphabet();
        test_random();
        settle();

        $display("Covered %0d loads and %0d conversions over %0d radix settings;",
                 n_loads, n_converts, n_cfg);
        $display("%0d characters checked, %0d mismatches.", n_chars, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/i2rd_pkg.sv
src/i2rd_ctrl.sv
src/i2rd_dp.sv
src/int_to_radix_digits.sv
src/i2rd_checker.sv
bench/tb.sv
